FILE: rtl/bf16_add_sub_assert.svh
// Assertion macros used by bf16_add_sub.
`ifndef BF16_ADD_SUB_ASSERT_SVH
`define BF16_ADD_SUB_ASSERT_SVH

// Asserts that cond implies next-cycle cons, checked only out of reset.
`define BAS_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

// Asserts that a condition holds at every clock edge out of reset.
`define BAS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

FILE: rtl/bas_pkg.sv
// ----------------------------------------------------------------------------
// bas_pkg
// Types and constants shared by the bfloat16 adder/subtractor stages.
// ----------------------------------------------------------------------------
package bas_pkg;

    localparam logic [7:0] IMPLICIT = 8'h80;
    localparam logic       OP_ADD   = 1'b0;
    localparam logic       OP_SUB   = 1'b1;

    // Stage 1 to stage 2: aligned magnitudes and the chosen operation.
    typedef struct packed {
        logic       is_sub;
        logic       sign;
        logic       flip;
        logic [7:0] exp;
        logic [7:0] ma;
        logic [7:0] mb;
    } t_align;

    // Stage 2 to stage 3: raw sum or difference before normalization.
    typedef struct packed {
        logic       is_sub;
        logic       sign;
        logic       flip;
        logic [7:0] exp;
        logic [8:0] mag;
    } t_sum;

endpackage

FILE: rtl/bas_align.sv
// ----------------------------------------------------------------------------
// bas_align
// Decodes the operation and operands and aligns the smaller mantissa.
// ----------------------------------------------------------------------------
module bas_align (
    input  logic              i_req_type,
    input  logic [15:0]       i_operand_a,
    input  logic [15:0]       i_operand_b,
    output bas_pkg::t_align   o_align
);
    logic       sa, sb, is_sub, sign, flip;
    logic [7:0] ea, eb, ma, mb, gap;

    always_comb begin
        sa = i_operand_a[15];
        sb = i_operand_b[15];
        ea = i_operand_a[14:7];
        eb = i_operand_b[14:7];
        ma = bas_pkg::IMPLICIT | {1'b0, i_operand_a[6:0]};
        mb = bas_pkg::IMPLICIT | {1'b0, i_operand_b[6:0]};
        flip = 1'b0;
        // Opposite signs: an add swaps operands so the positive one leads; a subtract keeps order.
        if (sa != sb) begin
            is_sub = (i_req_type == bas_pkg::OP_ADD);
            if (i_req_type == bas_pkg::OP_ADD && sa) begin
                sign = 1'b0;
                {ea, eb} = {eb, ea};
                {ma, mb} = {mb, ma};
            end else begin
                sign = 1'b0;
                flip = sa;
            end
        end else begin
            is_sub = (i_req_type == bas_pkg::OP_SUB);
            sign   = sa;
        end
        if (ea < eb) begin
            gap = eb - ea;
            ma  = (gap >= 8'd9) ? 8'd0 : (ma >> gap[3:0]);
            o_align.exp = eb;
        end else begin
            gap = ea - eb;
            mb  = (gap >= 8'd9) ? 8'd0 : (mb >> gap[3:0]);
            o_align.exp = ea;
        end
        o_align.is_sub = is_sub;
        o_align.sign   = sign;
        o_align.flip   = flip;
        o_align.ma     = ma;
        o_align.mb     = mb;
    end
endmodule

FILE: rtl/bas_norm.sv
// ----------------------------------------------------------------------------
// bas_norm
// Renormalizes a sum or difference and packs the result word.
// ----------------------------------------------------------------------------
module bas_norm (
    input  bas_pkg::t_sum  i_sum,
    output logic [15:0]    o_word
);
    logic [7:0] d, e;
    logic [3:0] lz;
    logic       s;

    always_comb begin
        d  = i_sum.mag[7:0];
        e  = i_sum.exp;
        s  = i_sum.sign;
        lz = 4'd0;
        if (!i_sum.is_sub) begin
            if (i_sum.mag[8]) begin
                d = i_sum.mag[8:1];
                e = e + 8'd1;
            end
            o_word = {s ^ i_sum.flip, e, d[6:0]};
        end else if (d == 8'd0) begin
            o_word = 16'h0000;
        end else begin
            // Only the leading one has no set bit above it.
            for (int k = 0; k < 8; k++) begin
                if (d[7 - k] && d >> (8 - k) == 8'd0) begin
                    lz = 4'(k);
                end
            end
            d = d << lz;
            e = e - {4'd0, lz};
            o_word = {s ^ i_sum.flip, e, d[6:0]};
        end
    end
endmodule

FILE: rtl/bf16_add_sub.sv
// ----------------------------------------------------------------------------
// bf16_add_sub
// Three-stage pipelined bfloat16 adder/subtractor with truncation.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   i_start / o_busy     i_req_type, i_operand_a, i_operand_b
//  result    o_done               o_result_word
//
// A transaction may enter every cycle; o_busy is always low.
// The result passes the stages align, add/subtract and normalize, each registered,
// and is on the ports with o_done high.
// Synchronous active-low reset clears the valid bits; the receiver cannot stall.
module bf16_add_sub (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_req_type,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    output logic        o_done,
    output logic [15:0] o_result_word
);
    `include "bf16_add_sub_assert.svh"

    bas_pkg::t_align n_align, r_align;
    bas_pkg::t_sum   n_sum, r_sum;
    logic [15:0]     n_word, r_word;
    logic            r_v1, r_v2, r_v3;

    bas_align u_align (
        .i_req_type  (i_req_type),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_align     (n_align)
    );

    always_comb begin
        n_sum.is_sub = r_align.is_sub;
        n_sum.flip   = r_align.flip;
        n_sum.exp    = r_align.exp;
        n_sum.sign   = r_align.sign;
        if (!r_align.is_sub) begin
            n_sum.mag = {1'b0, r_align.ma} + {1'b0, r_align.mb};
        end else if (r_align.ma >= r_align.mb) begin
            n_sum.mag = {1'b0, r_align.ma - r_align.mb};
        end else begin
            n_sum.mag  = {1'b0, r_align.mb - r_align.ma};
            n_sum.sign = ~r_align.sign;
        end
    end

    bas_norm u_norm (
        .i_sum  (r_sum),
        .o_word (n_word)
    );

    always_ff @(posedge i_clk) begin
        r_align <= n_align;
        r_sum   <= n_sum;
        r_word  <= n_word;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_busy        = 1'b0;
    assign o_done        = r_v3;
    assign o_result_word = r_word;

    `BAS_ASSERT_NEXT(a_flow, i_clk, i_rst_n, i_start, r_v1)
    `BAS_ASSERT_NEXT(a_done, i_clk, i_rst_n, r_v2, o_done)
    `BAS_ASSERT_ALWAYS(a_nobusy, i_clk, i_rst_n, !o_busy)
endmodule
